// ===== rtl/cba_pkg.sv =====
package cba_pkg;

	localparam int CBA_DISK_BLOCKS = 1024;
	localparam int CBA_MAX_FILES   = 128;

	localparam int KEY_W   = 64;
	localparam int START_W = 10;
	localparam int COUNT_W = 11;
	localparam int STAT_W  = 3;

	localparam logic OP_ALLOC  = 1'b0;
	localparam logic OP_SEARCH = 1'b1;

	localparam logic [STAT_W-1:0] STS_ALLOCATED = 3'd0;
	localparam logic [STAT_W-1:0] STS_BUSY      = 3'd1;
	localparam logic [STAT_W-1:0] STS_FULL      = 3'd2;
	localparam logic [STAT_W-1:0] STS_FOUND     = 3'd3;
	localparam logic [STAT_W-1:0] STS_NOT_FOUND = 3'd4;

	typedef struct packed {
		logic [KEY_W-1:0]   key;
		logic [START_W-1:0] first;
		logic [COUNT_W-1:0] count;
	} entry_t;

endpackage

// ===== rtl/cba_bitmap.sv =====
module cba_bitmap import cba_pkg::*; #(
	parameter int DEPTH = CBA_DISK_BLOCKS,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          re,
	input  logic          we,
	input  logic [AW-1:0] addr,
	input  logic          wdata,
	output logic          rdata
);

	logic mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

// ===== rtl/cba_table.sv =====
module cba_table import cba_pkg::*; #(
	parameter int DEPTH = CBA_MAX_FILES,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  entry_t        wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output entry_t        rdata
);

	entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/cba_ctrl.sv =====
module cba_ctrl import cba_pkg::*; #(
	parameter int DISK_BLOCKS = CBA_DISK_BLOCKS,
	parameter int MAX_FILES   = CBA_MAX_FILES,
	localparam int BW    = $clog2(DISK_BLOCKS),
	localparam int FW    = $clog2(MAX_FILES),
	localparam int FCW   = $clog2(MAX_FILES + 1),
	localparam int SUM_W = ($clog2(DISK_BLOCKS + 1) > COUNT_W + 1) ?
		$clog2(DISK_BLOCKS + 1) : COUNT_W + 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               op,
	input  logic [KEY_W-1:0]   file_key,
	input  logic [START_W-1:0] start_block,
	input  logic [COUNT_W-1:0] block_count,
	output logic               done,
	output logic [STAT_W-1:0]  status,
	output logic [START_W-1:0] found_start,
	output logic [COUNT_W-1:0] found_count,
	output logic               bm_re,
	output logic               bm_we,
	output logic [BW-1:0]      bm_addr,
	output logic               bm_wdata,
	input  logic               bm_rdata,
	output logic               tbl_we,
	output logic [FW-1:0]      tbl_waddr,
	output entry_t             tbl_wdata,
	output logic               tbl_re,
	output logic [FW-1:0]      tbl_raddr,
	input  entry_t             tbl_rdata
);

	localparam logic [2:0] S_CLEAR  = 3'd0;
	localparam logic [2:0] S_IDLE   = 3'd1;
	localparam logic [2:0] S_CHECK  = 3'd2;
	localparam logic [2:0] S_MARK   = 3'd3;
	localparam logic [2:0] S_SEARCH = 3'd4;

	localparam logic [SUM_W-1:0] DISK_LIM  = SUM_W'(DISK_BLOCKS);
	localparam logic [BW-1:0]    LAST_BLK  = BW'(DISK_BLOCKS - 1);
	localparam logic [FCW-1:0]   FILES_LIM = FCW'(MAX_FILES);

	logic [2:0]         state_q;
	logic [BW-1:0]      cur_q;
	logic [COUNT_W-1:0] remain_q;
	logic               pend_s1;
	logic [FCW-1:0]     iss_q;
	logic [FCW-1:0]     files_q;
	logic               done_q;
	logic [KEY_W-1:0]   key_q;
	logic [START_W-1:0] first_q;
	logic [COUNT_W-1:0] count_q;
	logic [STAT_W-1:0]  status_q;
	logic [START_W-1:0] fstart_q;
	logic [COUNT_W-1:0] fcount_q;

	logic [SUM_W-1:0]   first_ext;
	logic [SUM_W-1:0]   range_end;
	logic               accept;
	logic               range_bad;
	logic               full;
	logic               check_fail;
	logic               check_ok;
	logic               mark_last;
	logic               hit;
	logic               miss_end;
	logic               zero_alloc;
	logic               res_valid;
	logic [STAT_W-1:0]  res_status;
	logic [START_W-1:0] res_start;
	logic [COUNT_W-1:0] res_count;

	assign first_ext  = SUM_W'(start_block);
	assign range_end  = first_ext + SUM_W'(block_count);
	assign accept     = start && (state_q == S_IDLE);
	assign range_bad  = range_end > DISK_LIM;
	assign full       = files_q == FILES_LIM;

	assign check_fail = (state_q == S_CHECK) && pend_s1 && bm_rdata;
	assign check_ok   = (state_q == S_CHECK) && pend_s1 && !bm_rdata &&
		(remain_q == '0);
	assign mark_last  = (state_q == S_MARK) && (remain_q == COUNT_W'(1));
	assign hit        = (state_q == S_SEARCH) && pend_s1 && (tbl_rdata.key == key_q);
	assign miss_end   = (state_q == S_SEARCH) && pend_s1 && !hit && (iss_q == files_q);
	assign zero_alloc = accept && (op == OP_ALLOC) && !range_bad &&
		(block_count == '0) && !full;

	assign bm_re    = (state_q == S_CHECK) && (remain_q != '0);
	assign bm_we    = (state_q == S_CLEAR) || (state_q == S_MARK);
	assign bm_addr  = cur_q;
	assign bm_wdata = state_q == S_MARK;

	assign tbl_we    = zero_alloc || mark_last;
	assign tbl_waddr = files_q[FW-1:0];
	assign tbl_re    = (state_q == S_SEARCH) && (iss_q != files_q);
	assign tbl_raddr = iss_q[FW-1:0];

	always_comb begin
		if (zero_alloc) begin
			tbl_wdata.key   = file_key;
			tbl_wdata.first = start_block;
			tbl_wdata.count = block_count;
		end else begin
			tbl_wdata.key   = key_q;
			tbl_wdata.first = first_q;
			tbl_wdata.count = count_q;
		end
	end

	always_comb begin
		res_valid  = 1'b0;
		res_status = STS_NOT_FOUND;
		res_start  = '0;
		res_count  = '0;
		if (accept) begin
			if (op == OP_SEARCH) begin
				res_valid  = files_q == '0;
				res_status = STS_NOT_FOUND;
			end else if (range_bad) begin
				res_valid  = 1'b1;
				res_status = STS_BUSY;
			end else if (block_count == '0) begin
				res_valid  = 1'b1;
				res_status = full ? STS_FULL : STS_ALLOCATED;
			end
		end else if (check_fail) begin
			res_valid  = 1'b1;
			res_status = STS_BUSY;
		end else if (check_ok && full) begin
			res_valid  = 1'b1;
			res_status = STS_FULL;
		end else if (mark_last) begin
			res_valid  = 1'b1;
			res_status = STS_ALLOCATED;
		end else if (hit) begin
			res_valid  = 1'b1;
			res_status = STS_FOUND;
			res_start  = tbl_rdata.first;
			res_count  = tbl_rdata.count;
		end else if (miss_end) begin
			res_valid  = 1'b1;
			res_status = STS_NOT_FOUND;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			cur_q    <= '0;
			remain_q <= '0;
			pend_s1  <= 1'b0;
			iss_q    <= '0;
			files_q  <= '0;
			done_q   <= 1'b0;
		end else begin
			done_q <= res_valid;
			if (tbl_we) begin
				files_q <= files_q + FCW'(1);
			end
			case (state_q)
				S_CLEAR: begin
					if (cur_q == LAST_BLK) begin
						cur_q   <= '0;
						state_q <= S_IDLE;
					end else begin
						cur_q <= cur_q + BW'(1);
					end
				end
				S_IDLE: begin
					pend_s1 <= 1'b0;
					if (accept) begin
						if (op == OP_SEARCH) begin
							iss_q <= '0;
							if (files_q != '0) begin
								state_q <= S_SEARCH;
							end
						end else if (!range_bad && (block_count != '0)) begin
							cur_q    <= first_ext[BW-1:0];
							remain_q <= block_count;
							state_q  <= S_CHECK;
						end
					end
				end
				S_CHECK: begin
					pend_s1 <= bm_re;
					if (bm_re) begin
						cur_q    <= cur_q + BW'(1);
						remain_q <= remain_q - COUNT_W'(1);
					end
					if (check_fail) begin
						state_q <= S_IDLE;
					end else if (check_ok) begin
						if (full) begin
							state_q <= S_IDLE;
						end else begin
							cur_q    <= SUM_W'(first_q) > DISK_LIM ? '0 :
								BW'(SUM_W'(first_q));
							remain_q <= count_q;
							state_q  <= S_MARK;
						end
					end
				end
				S_MARK: begin
					cur_q    <= cur_q + BW'(1);
					remain_q <= remain_q - COUNT_W'(1);
					if (mark_last) begin
						state_q <= S_IDLE;
					end
				end
				S_SEARCH: begin
					pend_s1 <= tbl_re;
					if (tbl_re) begin
						iss_q <= iss_q + FCW'(1);
					end
					if (hit || miss_end) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			key_q   <= file_key;
			first_q <= start_block;
			count_q <= block_count;
		end
		if (res_valid) begin
			status_q <= res_status;
			fstart_q <= res_start;
			fcount_q <= res_count;
		end
	end

	assign busy        = state_q != S_IDLE;
	assign done        = done_q;
	assign status      = status_q;
	assign found_start = fstart_q;
	assign found_count = fcount_q;

endmodule

// ===== rtl/contiguous_block_allocator.sv =====
// Channel   Beat marked by        Fields
// request   start && !busy        op, file_key, start_block, block_count
// result    done (one cycle)      status, found_start, found_count
//
// Allocate of n blocks through the one-bit bitmap memory port: one check read per
// block, stopping at a taken block, then one mark write per block. Off-disk or
// zero-length: answered with no bitmap pass. Search: one file table read per cycle.
// After reset a clearing pass writes the bitmap, busy high.
// The receiver cannot stall: each result beat is shown for exactly one cycle.
module contiguous_block_allocator import cba_pkg::*; #(
	parameter int DISK_BLOCKS = CBA_DISK_BLOCKS,
	parameter int MAX_FILES   = CBA_MAX_FILES
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               op,
	input  logic [KEY_W-1:0]   file_key,
	input  logic [START_W-1:0] start_block,
	input  logic [COUNT_W-1:0] block_count,
	output logic               done,
	output logic [STAT_W-1:0]  status,
	output logic [START_W-1:0] found_start,
	output logic [COUNT_W-1:0] found_count
);

	localparam int BW = $clog2(DISK_BLOCKS);
	localparam int FW = $clog2(MAX_FILES);

	logic          bm_re;
	logic          bm_we;
	logic [BW-1:0] bm_addr;
	logic          bm_wdata;
	logic          bm_rdata;
	logic          tbl_we;
	logic [FW-1:0] tbl_waddr;
	entry_t        tbl_wdata;
	logic          tbl_re;
	logic [FW-1:0] tbl_raddr;
	entry_t        tbl_rdata;

	cba_ctrl #(
		.DISK_BLOCKS(DISK_BLOCKS),
		.MAX_FILES(MAX_FILES)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.op(op),
		.file_key(file_key),
		.start_block(start_block),
		.block_count(block_count),
		.done(done),
		.status(status),
		.found_start(found_start),
		.found_count(found_count),
		.bm_re(bm_re),
		.bm_we(bm_we),
		.bm_addr(bm_addr),
		.bm_wdata(bm_wdata),
		.bm_rdata(bm_rdata),
		.tbl_we(tbl_we),
		.tbl_waddr(tbl_waddr),
		.tbl_wdata(tbl_wdata),
		.tbl_re(tbl_re),
		.tbl_raddr(tbl_raddr),
		.tbl_rdata(tbl_rdata)
	);

	cba_bitmap #(
		.DEPTH(DISK_BLOCKS)
	) u_bitmap (
		.clk(clk),
		.re(bm_re),
		.we(bm_we),
		.addr(bm_addr),
		.wdata(bm_wdata),
		.rdata(bm_rdata)
	);

	cba_table #(
		.DEPTH(MAX_FILES)
	) u_table (
		.clk(clk),
		.we(tbl_we),
		.waddr(tbl_waddr),
		.wdata(tbl_wdata),
		.re(tbl_re),
		.raddr(tbl_raddr),
		.rdata(tbl_rdata)
	);

	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy || done)
		else $error("accepted request neither in progress nor answered");

	a_table_write_alloc: assert property (@(posedge clk) disable iff (!arst_n)
		tbl_we |=> done && (status == STS_ALLOCATED))
		else $error("file table written without allocated result");

	a_bitmap_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		bm_we |-> busy && !bm_re)
		else $error("bitmap written outside a clear or mark pass");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status != STS_FOUND) |-> (found_start == '0) && (found_count == '0))
		else $error("nonzero found fields without a match");

endmodule

// ===== tb/contiguous_block_allocator_test.sv =====
module contiguous_block_allocator_test;
	import cba_pkg::*;

	localparam int STALL_LIMIT = 12000;
	localparam int DRAIN_CYCLES = 64;

	typedef struct {
		logic               op;
		logic [KEY_W-1:0]   key;
		logic [START_W-1:0] first;
		logic [COUNT_W-1:0] count;
	} request_t;

	typedef struct {
		logic [STAT_W-1:0]  status;
		logic [START_W-1:0] found_start;
		logic [COUNT_W-1:0] found_count;
	} outcome_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic               op = OP_ALLOC;
	logic [KEY_W-1:0]   file_key = '0;
	logic [START_W-1:0] start_block = '0;
	logic [COUNT_W-1:0] block_count = '0;
	logic               done;
	logic [STAT_W-1:0]  status;
	logic [START_W-1:0] found_start;
	logic [COUNT_W-1:0] found_count;

	request_t    request_q[$];
	outcome_t    outcome_q[$];
	logic [KEY_W-1:0] issued_keys[$];

	logic        disk_map[CBA_DISK_BLOCKS];
	entry_t      file_table[CBA_MAX_FILES];
	int          files_held = 0;

	int          total_items = 0;
	int          accepted = 0;
	int          checked = 0;
	int          mismatches = 0;
	int          beat_errs;
	int          quiet_cycles = 0;
	logic        stalled = 1'b0;
	request_t    next_req;
	outcome_t    predicted;
	outcome_t    awaited;

	contiguous_block_allocator u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.op         (op),
		.file_key   (file_key),
		.start_block(start_block),
		.block_count(block_count),
		.done       (done),
		.status     (status),
		.found_start(found_start),
		.found_count(found_count)
	);

	always #4 clk = ~clk;

	function automatic outcome_t serve_request(input request_t r);
		outcome_t o;
		logic     fits;
		int       b;
		o.status = STS_NOT_FOUND;
		o.found_start = '0;
		o.found_count = '0;
		if (r.op == OP_ALLOC) begin
			fits = (int'(r.first) + int'(r.count) <= CBA_DISK_BLOCKS);
			if (fits) begin
				for (b = int'(r.first); b < int'(r.first) + int'(r.count); b++)
					if (disk_map[b])
						fits = 1'b0;
			end
			if (!fits) begin
				o.status = STS_BUSY;
			end else if (files_held >= CBA_MAX_FILES) begin
				o.status = STS_FULL;
			end else begin
				for (b = int'(r.first); b < int'(r.first) + int'(r.count); b++)
					disk_map[b] = 1'b1;
				file_table[files_held] = '{key: r.key, first: r.first, count: r.count};
				files_held++;
				o.status = STS_ALLOCATED;
			end
		end else begin
			for (b = 0; b < files_held; b++) begin
				if (o.status == STS_NOT_FOUND && file_table[b].key == r.key) begin
					o.status = STS_FOUND;
					o.found_start = file_table[b].first;
					o.found_count = file_table[b].count;
				end
			end
		end
		return o;
	endfunction

	function automatic int sender_idle_pct(input int n);
		if (n < total_items / 3)
			return 27;
		else if (n < 2 * total_items / 3)
			return 56;
		return 0;
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) begin
				predicted = serve_request('{op: op, key: file_key,
					first: start_block, count: block_count});
				outcome_q.push_back(predicted);
				accepted <= accepted + 1;
			end
			if (!start || !busy) begin
				if (request_q.size() != 0 && $urandom_range(99) >= sender_idle_pct(accepted)) begin
					next_req = request_q.pop_front();
					start <= 1'b1;
					op <= next_req.op;
					file_key <= next_req.key;
					start_block <= next_req.first;
					block_count <= next_req.count;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && done) begin
			beat_errs = 0;
			if (outcome_q.size() == 0) begin
				$error("result beat with no request outstanding");
				beat_errs = 1;
			end else begin
				awaited = outcome_q.pop_front();
				if (status !== awaited.status) begin
					$error("status: expected %0d, got %0d", awaited.status, status);
					beat_errs++;
				end
				if (found_start !== awaited.found_start) begin
					$error("found_start: expected %0d, got %0d", awaited.found_start,
						found_start);
					beat_errs++;
				end
				if (found_count !== awaited.found_count) begin
					$error("found_count: expected %0d, got %0d", awaited.found_count,
						found_count);
					beat_errs++;
				end
				checked <= checked + 1;
			end
			mismatches <= mismatches + beat_errs;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done)
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT)
				stalled <= 1'b1;
		end
	end

	task automatic queue_alloc(input logic [KEY_W-1:0] key, input int first, input int count);
		request_q.push_back('{op: OP_ALLOC, key: key, first: START_W'(first),
			count: COUNT_W'(count)});
		issued_keys.push_back(key);
	endtask

	task automatic queue_search(input logic [KEY_W-1:0] key);
		request_q.push_back('{op: OP_SEARCH, key: key, first: START_W'($urandom_range(1023)),
			count: COUNT_W'($urandom_range(2047))});
	endtask

	initial begin
		logic [KEY_W-1:0] key;
		int               roll;
		int               count;
		int               n;

		for (n = 0; n < CBA_DISK_BLOCKS; n++)
			disk_map[n] = 1'b0;

		// directed: empty table, zero length, overlap, off disk, duplicates
		queue_search(64'h0);
		queue_alloc(64'h0, 0, 0);
		queue_alloc({KEY_W{1'b1}}, 0, 4);
		queue_alloc(64'h6b65726e656c2e78, 2, 3);
		queue_alloc(64'h6b65726e656c2e78, 1020, 5);
		queue_alloc(64'h6b65726e656c2e78, 1, 1024);
		queue_alloc(64'h6b65726e656c2e78, 1023, 1);
		queue_alloc(64'h737761702e646174, 0, 1024);
		queue_alloc({KEY_W{1'b1}}, 10, 2);
		queue_search({KEY_W{1'b1}});
		queue_search(64'h0);
		queue_search(64'h6b65726e656c2e78);
		queue_alloc(64'h737761702e646174, 1023, 0);
		queue_search(64'h737761702e646174);
		queue_search(64'h737761702e646175);
		queue_alloc(64'h6c6f672e74787400, 4, 6);
		queue_alloc(64'h6c6f672e74787400, 1000, 100);
		queue_search(64'h6c6f672e74787400);

		// random: table fills up part way through, then full and busy dominate
		for (n = 0; n < 830; n++) begin
			roll = $urandom_range(99);
			if (roll < 50) begin
				if ($urandom_range(9) == 0)
					key = issued_keys[$urandom_range(issued_keys.size() - 1)];
				else
					key = {$urandom, $urandom};
				roll = $urandom_range(99);
				if (roll < 2)
					count = $urandom_range(1024);
				else if (roll < 17)
					count = 0;
				else
					count = $urandom_range(4, 1);
				queue_alloc(key, $urandom_range(1023), count);
			end else begin
				roll = $urandom_range(99);
				if (roll < 70)
					key = issued_keys[$urandom_range(issued_keys.size() - 1)];
				else if (roll < 85)
					key = issued_keys[$urandom_range(issued_keys.size() - 1)] ^
						(64'h1 << $urandom_range(63));
				else
					key = {$urandom, $urandom};
				queue_search(key);
			end
		end
		total_items = request_q.size();

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		wait (stalled || (accepted == total_items && checked == accepted));
		if (!stalled)
			repeat (DRAIN_CYCLES) @(posedge clk);
		if (!stalled && mismatches == 0 && outcome_q.size() == 0)
			$display("contiguous_block_allocator_test passed");
		else
			$display("contiguous_block_allocator_test failed");
		$finish;
	end

endmodule

// ===== contiguous_block_allocator.f =====
rtl/cba_pkg.sv
rtl/cba_bitmap.sv
rtl/cba_table.sv
rtl/cba_ctrl.sv
rtl/contiguous_block_allocator.sv
tb/contiguous_block_allocator_test.sv
